>>> sv/ndr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nixie refresh package
// Shared types, register indexes and the per-tube cathode table.
// ----------------------------------------------------------------------------
package ndr_pkg;

    // Tube and code geometry.
    localparam int TUBES     = 8;
    localparam int CODES     = 12;
    localparam int CODE_W    = 4;
    localparam int CATH_W    = 7;
    localparam int PATTERN_W = 96;
    localparam int LOW_W     = 64;
    localparam int HIGH_W    = 32;

    // Codes 11 and above wrap to zero when the digits are advanced.
    localparam logic [CODE_W-1:0] WRAP_CODE = 4'd11;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXERCISE   = 1'b1;

    typedef logic [TUBES-1:0][CODE_W-1:0] digits_t;
    typedef logic [PATTERN_W-1:0]         pattern_t;

    // Cathode number (1 to 96) for each tube row and code column.
    localparam logic [CATH_W-1:0] CATHODE_MAP [TUBES][CODES] = '{
        '{ 2, 11, 10,  9,  8,  7,  6,  5,  4,  3, 13,  1},
        '{14, 24, 23, 21, 22, 20, 18, 16, 17, 15, 19, 12},
        '{26, 35, 34, 33, 32, 31, 30, 29, 28, 27, 36, 25},
        '{38, 47, 46, 45, 44, 43, 42, 41, 40, 39, 48, 37},
        '{50, 59, 58, 57, 56, 55, 54, 53, 52, 51, 60, 49},
        '{62, 71, 70, 69, 68, 67, 66, 65, 64, 63, 72, 61},
        '{74, 83, 79, 81, 82, 80, 78, 76, 77, 75, 84, 73},
        '{85, 95, 94, 93, 92, 91, 90, 89, 88, 87, 96, 86}
    };

endpackage

>>> sv/ndr_pattern.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nixie cathode pattern decoder
// Maps eight digit codes through the per-tube cathode table to a 96-bit
// latch pattern, bit m-1 set for cathode m. Codes 12 to 15 light nothing.
// ----------------------------------------------------------------------------
module ndr_pattern
(
    input  ndr_pkg::digits_t  digits,
    output ndr_pkg::pattern_t pattern
);

    // One independent table lookup per tube, ORed into the pattern.
    always_comb
    begin
        logic [2:0]                      tube;
        logic [ndr_pkg::CODE_W-1:0]      code;
        logic [ndr_pkg::CATH_W-1:0]      cath;
        pattern = '0;
        cath    = '0;
        for (int i = 0; i < ndr_pkg::TUBES; i++)
        begin
            // Position i uses the table row counted from the far end.
            tube = 3'(ndr_pkg::TUBES - 1 - i);
            code = digits[i];
            if (code < ndr_pkg::CODE_W'(ndr_pkg::CODES))
            begin
                cath = ndr_pkg::CATHODE_MAP[tube][code];
                pattern[cath - 7'd1] = 1'b1;
            end
        end
    end

endmodule

>>> sv/nixie_digit_refresh_pwm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nixie digit refresh with brightness PWM
// Eight-tube digit store, PWM blanking, cathode exercise and 96-bit latch.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals                        Word
//  s_*      in         tvalid/tready/tdata/tuser      cmd, eight digit codes
//  m_*      out        tvalid/tready/tdata/tuser      flags, 96-bit pattern
//  cfg_*    in         cfg_we/cfg_index/cfg_wdata     brightness, exercise
//
//  Each word passes an input register and a result register: m_tvalid rises
//  when the word reaches the result register; one word is taken every cycle unless m_tready stalls.
//  The eight cathode table lookups between those registers set the cycle.
//  A stall on m_tready holds the result register, then the input register,
//  and only then drops s_tready. Reset clears the digit store, the PWM and
//  exercise counters and the latch, and sets brightness to 7.
// ----------------------------------------------------------------------------
module nixie_digit_refresh_pwm
#(
    parameter int PWM_STEPS       = 8,
    parameter int EXERCISE_PERIOD = 10
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // digit_0 [3:0] ... digit_7 [31:28]
    input  logic        s_tuser,   // cmd: 0 refresh tick, 1 load digits

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // pattern_low [63:0], pattern_high [95:64]
    output logic [1:0]  m_tuser,   // display_on [0], latch_load [1]

    input  logic                             cfg_we,
    input  logic [ndr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ndr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int PHASE_W = (PWM_STEPS > 2) ? $clog2(PWM_STEPS) : 1;
    localparam int EX_W    = (EXERCISE_PERIOD > 1) ? $clog2(EXERCISE_PERIOD + 1) : 1;
    localparam int CMP_W   = (PHASE_W > ndr_pkg::CFG_DATA_W) ? PHASE_W : ndr_pkg::CFG_DATA_W;

    // Configuration registers.
    logic [2:0] brightness_reg;
    logic       exercise_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg  <= 3'd7;
            exercise_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ndr_pkg::REG_BRIGHTNESS: brightness_reg  <= cfg_wdata;
                ndr_pkg::REG_EXERCISE:   exercise_en_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Pipeline handshake: input register feeds the result register.
    logic             in_valid_reg;
    logic             in_cmd_reg;
    ndr_pkg::digits_t in_digits_reg;
    logic             m_valid_reg;
    logic             out_free;
    logic             proc;

    assign out_free = !m_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (proc)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg    <= s_tuser;
            in_digits_reg <= ndr_pkg::digits_t'(s_tdata);
        end
    end

    // Engine state.
    ndr_pkg::digits_t   digit_store_reg;
    logic [PHASE_W-1:0] pwm_phase_reg;
    logic [EX_W-1:0]    ex_phase_reg;
    ndr_pkg::pattern_t  latched_reg;
    logic               lit_reg;

    // Lit decision and the optional exercise advance of every digit.
    logic               lit;
    logic               advance;
    ndr_pkg::digits_t   digits_adv;
    ndr_pkg::pattern_t  pattern_new;

    assign lit     = CMP_W'(pwm_phase_reg) <= CMP_W'(brightness_reg);
    assign advance = exercise_en_reg && (ex_phase_reg == EX_W'(EXERCISE_PERIOD));

    always_comb
    begin
        for (int i = 0; i < ndr_pkg::TUBES; i++)
        begin
            if (!advance)
                digits_adv[i] = digit_store_reg[i];
            else if (digit_store_reg[i] >= ndr_pkg::WRAP_CODE)
                digits_adv[i] = '0;
            else
                digits_adv[i] = digit_store_reg[i] + 4'd1;
        end
    end

    ndr_pattern u_pattern
    (
        .digits  (digits_adv),
        .pattern (pattern_new)
    );

    // State update for each processed word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_store_reg <= '0;
            pwm_phase_reg   <= '0;
            ex_phase_reg    <= '0;
            latched_reg     <= '0;
            lit_reg         <= 1'b0;
        end
        else if (proc)
        begin
            if (in_cmd_reg)
            begin
                digit_store_reg <= in_digits_reg;
            end
            else
            begin
                if (lit)
                begin
                    digit_store_reg <= digits_adv;
                    latched_reg     <= pattern_new;
                end
                lit_reg <= lit;

                if (pwm_phase_reg == PHASE_W'(PWM_STEPS - 1))
                    pwm_phase_reg <= '0;
                else
                    pwm_phase_reg <= pwm_phase_reg + PHASE_W'(1);

                if (ex_phase_reg >= EX_W'(EXERCISE_PERIOD))
                    ex_phase_reg <= '0;
                else
                    ex_phase_reg <= ex_phase_reg + EX_W'(1);
            end
        end
    end

    // Result register.
    logic              res_display_reg;
    logic              res_load_reg;
    ndr_pkg::pattern_t res_pattern_reg;
    logic              load_now;

    assign load_now = !in_cmd_reg && lit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (proc)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            res_display_reg <= in_cmd_reg ? lit_reg : lit;
            res_load_reg    <= load_now;
            res_pattern_reg <= load_now ? pattern_new : latched_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_pattern_reg;
    assign m_tuser  = {res_load_reg, res_display_reg};

    // A latched pattern always goes out with the tubes lit.
    a_load_implies_lit: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && res_load_reg |-> res_display_reg)
        else $error("latch_load without display_on");

    // A digit load leaves both counters where they were.
    a_load_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_cmd_reg |=> $stable(pwm_phase_reg) && $stable(ex_phase_reg))
        else $error("counters moved on a digit load");

    // The PWM phase stays below the step count.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pwm_phase_reg) < PWM_STEPS)
        else $error("PWM phase out of range");

    // The exercise counter never passes its period.
    a_ex_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ex_phase_reg) <= EXERCISE_PERIOD)
        else $error("exercise counter out of range");

    // A tick above the brightness setting blanks and keeps the latch.
    a_blank_tick: assert property (@(posedge clk) disable iff (!rst_n)
        proc && !in_cmd_reg && !lit |=> !lit_reg && $stable(latched_reg))
        else $error("blank tick changed the latch");

endmodule

>>> dv/nixie_digit_refresh_pwm_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nixie digit refresh testbench
// Drives load and tick words into the refresh engine and holds a cycle-free
// model of the digit store, the PWM and exercise counters and the cathode
// latch. Each accepted word queues the expected result, and every result word
// is checked field by field against the oldest entry. Directed tests cover
// the code extremes, blanking and exercise wrap. Random phases run under
// several register settings with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module nixie_digit_refresh_pwm_tb;

    localparam int PWM_STEPS       = 8;
    localparam int EXERCISE_PERIOD = 10;
    localparam int CLK_HALF        = 10;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 10;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_WORDS     = 284;

    typedef enum logic
    {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } refresh_cmd_t;

    // One expected result word.
    typedef struct packed
    {
        logic              display_on;
        logic              latch_load;
        ndr_pkg::pattern_t pattern;
    } refresh_word_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [31:0]                    s_tdata = '0;   // digit_0 [3:0] ... digit_7 [31:28]
    logic                           s_tuser = 1'b0; // cmd
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [95:0]                    m_tdata;        // pattern_low [63:0], pattern_high [95:64]
    logic [1:0]                     m_tuser;        // display_on [0], latch_load [1]
    logic                           cfg_we = 1'b0;
    logic [ndr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ndr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow state of the refresh engine.
    ndr_pkg::digits_t  tube_codes    = '0;
    int unsigned       pwm_phase     = 0;
    int unsigned       drill_phase   = 0;
    ndr_pkg::pattern_t latch_pattern = '0;
    logic              lit           = 1'b0;
    logic [2:0]        bright_set    = 3'd7;
    logic              drill_on      = 1'b0;

    refresh_word_t   expected_words[$];
    int              mismatches  = 0;
    int              cycle_count = 0;
    int              burst_left  = 0;
    int              rx_count    = 0;
    int              rx_mode     = 0;

    nixie_digit_refresh_pwm
    #(
        .PWM_STEPS       (PWM_STEPS),
        .EXERCISE_PERIOD (EXERCISE_PERIOD)
    )
    i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    // Advance the shadow engine by one accepted word and return its result.
    function automatic refresh_word_t refresh_predict(input refresh_cmd_t cmd,
                                                      input ndr_pkg::digits_t codes);
        refresh_word_t               word;
        ndr_pkg::pattern_t           pat;
        logic [ndr_pkg::CODE_W-1:0]  code;
        int                          cath;
        word.latch_load = 1'b0;
        if (cmd == CMD_LOAD)
        begin
            tube_codes = codes;
        end
        else
        begin
            if (pwm_phase <= bright_set)
            begin
                // Exercise step: codes at or above the wrap code go back to zero.
                if (drill_on && drill_phase == EXERCISE_PERIOD)
                begin
                    for (int t = 0; t < ndr_pkg::TUBES; t++)
                    begin
                        tube_codes[t] = (tube_codes[t] >= ndr_pkg::WRAP_CODE) ? 4'd0 :
                                        tube_codes[t] + 4'd1;
                    end
                end
                // Tube t uses table row TUBES-1-t; blank codes light nothing.
                pat = '0;
                for (int t = 0; t < ndr_pkg::TUBES; t++)
                begin
                    code = tube_codes[t];
                    if (code < ndr_pkg::CODES)
                    begin
                        cath = int'(ndr_pkg::CATHODE_MAP[ndr_pkg::TUBES - 1 - t][code]);
                        pat[cath - 1] = 1'b1;
                    end
                end
                latch_pattern   = pat;
                lit             = 1'b1;
                word.latch_load = 1'b1;
            end
            else
            begin
                lit = 1'b0;
            end
            pwm_phase   = (pwm_phase + 1 >= PWM_STEPS) ? 0 : pwm_phase + 1;
            drill_phase = (drill_phase >= EXERCISE_PERIOD) ? 0 : drill_phase + 1;
        end
        word.display_on = lit;
        word.pattern    = latch_pattern;
        return word;
    endfunction

    function automatic void check_field(input string field, input logic [95:0] want,
                                        input logic [95:0] got);
        if (want !== got)
        begin
            if (mismatches < MAX_REPORTS)
            begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
            end
            mismatches++;
        end
    endfunction

    // Present one word and wait until it is taken.
    task automatic send_word(input refresh_cmd_t cmd, input ndr_pkg::digits_t codes);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= codes;
        do
            @(posedge clk);
        while (!s_tready);
        expected_words.push_back(refresh_predict(cmd, codes));
    endtask

    // Bursts of random length with random gaps between them.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Hold the input side until every expected word has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ndr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ndr_pkg::CFG_DATA_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ndr_pkg::REG_BRIGHTNESS)
            bright_set = value;
        else if (idx == ndr_pkg::REG_EXERCISE)
            drill_on = value[0];
    endtask

    task automatic tick();
        send_word(CMD_TICK, $urandom());
    endtask

    // Power-up state, then all-blank and all-zero codes.
    task automatic test_power_up();
        tick();
        send_word(CMD_LOAD, 32'hFFFF_FFFF);
        tick();
        send_word(CMD_LOAD, 32'h0000_0000);
        tick();
    endtask

    // Each of the sixteen codes once: code i on tube i, then code i+8 on tube i.
    task automatic test_cathode_codes();
        send_word(CMD_LOAD, 32'h7654_3210);
        tick();
        send_word(CMD_LOAD, 32'hFEDC_BA98);
        tick();
    endtask

    // Brightness zero: one lit phase out of eight, load while blanked.
    task automatic test_blanking();
        write_reg(ndr_pkg::REG_BRIGHTNESS, 3'd0);
        repeat (4) tick();
        send_word(CMD_LOAD, 32'h0123_4567);
        tick();
    endtask

    // Exercise mode with wrapping codes; eleven ticks span a full exercise period.
    task automatic test_exercise();
        write_reg(ndr_pkg::REG_BRIGHTNESS, 3'd7);
        write_reg(ndr_pkg::REG_EXERCISE, 3'b111);
        send_word(CMD_LOAD, 32'hFDCB_A910);
        repeat (11) tick();
    endtask

    task automatic send_random_word();
        ndr_pkg::digits_t codes;
        refresh_cmd_t     cmd;
        cmd = ($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_TICK;
        for (int t = 0; t < ndr_pkg::TUBES; t++)
        begin
            codes[t] = $urandom_range(0, 1) ? 4'($urandom_range(0, 11)) :
                                              4'($urandom_range(0, 15));
        end
        pace_sender();
        send_word(cmd, codes);
    endtask

    // Random words under several register settings, extremes included.
    task automatic test_random();
        logic [ndr_pkg::CFG_DATA_W-1:0] bright;
        logic                           drill;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       bright = 3'd7;
                1:       bright = 3'd0;
                default: bright = 3'($urandom_range(0, 7));
            endcase
            drill = (phase == 2 || phase == 4) ? 1'b1 :
                    (phase == 3)               ? 1'b0 : 1'($urandom_range(0, 1));
            write_reg(ndr_pkg::REG_BRIGHTNESS, bright);
            write_reg(ndr_pkg::REG_EXERCISE, {2'($urandom_range(0, 3)), drill});
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (phase == 2 && n == PHASE_WORDS / 2)
                    drain();
                send_random_word();
            end
        end
    endtask

    // Output side stalls on a pattern that changes mode now and then.
    always @(posedge clk)
    begin
        rx_count++;
        if (rx_count % 97 == 0)
            rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= (rx_count % 11) < 4;
        endcase
    end

    // Compare each result word with the oldest expectation.
    always @(posedge clk)
    begin : check_words
        refresh_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: result word with nothing expected: %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("display_on", 96'(want.display_on), 96'(m_tuser[0]));
                check_field("latch_load", 96'(want.latch_load), 96'(m_tuser[1]));
                check_field("pattern_low", 96'(want.pattern[ndr_pkg::LOW_W-1:0]),
                            96'(m_tdata[ndr_pkg::LOW_W-1:0]));
                check_field("pattern_high",
                            96'(want.pattern[ndr_pkg::PATTERN_W-1:ndr_pkg::LOW_W]),
                            96'(m_tdata[ndr_pkg::PATTERN_W-1:ndr_pkg::LOW_W]));
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("nixie_digit_refresh_pwm regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_power_up();
        test_cathode_codes();
        test_blanking();
        test_exercise();
        test_random();
        drain();
        if (mismatches == 0 && expected_words.size() == 0)
            $display("nixie_digit_refresh_pwm regression: pass");
        else
            $display("nixie_digit_refresh_pwm regression: fail");
        $finish;
    end

endmodule
